// ===== sv/szc_pkg.sv =====
// Shared types and constants for the size-class slab allocator.
// Depends on nothing; every other file in sv/ uses it by scoped name.
`timescale 1ns / 1ps

package szc_pkg;

    localparam int CLASS_COUNT = 10;
    localparam int PAGE_BYTES  = 4096;
    localparam int CLS_W       = 4;
    localparam int ADDR_W      = 16;
    localparam int OFS_W       = 12;
    localparam int CARVE_W     = 9;
    localparam int ES_W        = 11;
    localparam int LINK_WORDS  = 8192;
    localparam int LINK_IDX_W  = 13;
    localparam int FRESH_W     = 5;
    localparam logic [ADDR_W-1:0] OFFSET_MASK = 16'h0fff;
    localparam logic [ES_W-1:0] MAX_CLASS_BYTES = 11'd1024;

    // entry size of each class
    localparam logic [ES_W-1:0] CLASS_BYTES [CLASS_COUNT] = '{
        11'd8, 11'd16, 11'd24, 11'd32, 11'd48,
        11'd64, 11'd128, 11'd256, 11'd512, 11'd1024
    };

    // entries per page: (PAGE_BYTES - size) / size, header slot excluded
    localparam logic [CARVE_W-1:0] CLASS_CAP [CLASS_COUNT] = '{
        9'd511, 9'd255, 9'd169, 9'd127, 9'd84,
        9'd63, 9'd31, 9'd15, 9'd7, 9'd3
    };

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERSIZE = 2'd1;
    localparam logic [1:0] ST_NO_PAGE  = 2'd2;
    localparam logic [1:0] ST_ALIGNED  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // classified request word passed from front to back
    typedef struct packed {
        logic              is_free;
        logic              oversize;
        logic [CLS_W-1:0]  cls;
        logic [ADDR_W-1:0] addr;
    } req_t;

    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_LINK = 2'b10
    } back_state_t;

endpackage

// ===== sv/szc_front.sv =====
// Front end: command handshake and size-class lookup of each request.
// Depends on szc_pkg.
`timescale 1ns / 1ps

module szc_front (
    input  logic                      start,
    input  logic                      op,
    input  logic [15:0]               request_size,
    input  logic [15:0]               free_address,
    input  logic                      q_full,
    output logic                      busy,
    output logic                      push,
    output szc_pkg::req_t             item
);

    logic [szc_pkg::CLS_W-1:0] cls;

    // smallest class that fits; scan from the top so the lowest match wins
    always_comb
    begin
        cls = '0;
        for (int c = szc_pkg::CLASS_COUNT - 1; c >= 0; c--)
        begin
            if (request_size <= 16'(szc_pkg::CLASS_BYTES[c]))
                cls = szc_pkg::CLS_W'(c);
        end
    end

    assign busy          = q_full;
    assign push          = start && !q_full;
    assign item.is_free  = (op == szc_pkg::OP_FREE);
    assign item.oversize = request_size > 16'(szc_pkg::MAX_CLASS_BYTES);
    assign item.cls      = cls;
    assign item.addr     = free_address;

endmodule

// ===== sv/szc_queue.sv =====
// Two-word queue between the front end and the back end.
// Depends on szc_pkg.
`timescale 1ns / 1ps

module szc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  szc_pkg::req_t wr_item,
    input  logic          pop,
    output logic          full,
    output logic          valid,
    output szc_pkg::req_t rd_item
);

    szc_pkg::req_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign rd_item = slot_reg[rd_ptr_reg];

endmodule

// ===== sv/szc_back.sv =====
// Back end: class state, page hand-out, freed-entry stacks and link memory.
// Depends on szc_pkg.
`timescale 1ns / 1ps

module szc_back #(
    parameter int POOL_PAGES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [4:0]    cfg_wdata,
    input  logic          q_valid,
    input  szc_pkg::req_t q_item,
    output logic          q_pop,
    output logic          done,
    output logic [15:0]   entry_address,
    output logic [1:0]    status
);

    localparam int OWN_DEPTH = (POOL_PAGES < 16) ? POOL_PAGES : 16;
    localparam logic [4:0] POOL_CAP = (POOL_PAGES < 32) ? 5'(POOL_PAGES) : 5'd31;

    szc_pkg::back_state_t state_reg;

    logic [15:0] head_reg      [szc_pkg::CLASS_COUNT];
    logic        nonempty_reg  [szc_pkg::CLASS_COUNT];
    logic [8:0]  carve_reg     [szc_pkg::CLASS_COUNT];
    logic [3:0]  class_page_reg[szc_pkg::CLASS_COUNT];
    logic [3:0]  owner_reg     [OWN_DEPTH];
    logic [4:0]  fresh_reg;
    logic [4:0]  page_limit_reg;

    logic [15:0] link_mem [szc_pkg::LINK_WORDS];
    logic [15:0] link_rdata_reg;

    logic [3:0]  link_cls_reg;
    logic [15:0] link_entry_reg;
    logic        done_reg;
    logic [15:0] addr_reg;
    logic [1:0]  status_reg;

    logic [3:0]  c_alloc;
    logic [3:0]  c_free;
    logic [3:0]  free_page;
    logic        stack_hit;
    logic        need_fresh;
    logic [4:0]  limit;
    logic        no_page;
    logic [9:0]  kp1;
    logic [3:0]  alloc_page;
    logic [20:0] prod;
    logic [15:0] alloc_addr;
    logic        free_owned;
    logic        run;
    logic        mem_we;
    logic        mem_re;

    always_comb
    begin
        c_alloc    = q_item.cls;
        free_page  = q_item.addr[15:12];
        c_free     = owner_reg[free_page];
        stack_hit  = nonempty_reg[c_alloc];
        need_fresh = carve_reg[c_alloc] >= szc_pkg::CLASS_CAP[c_alloc];
        limit      = (32'(page_limit_reg) < POOL_PAGES) ? page_limit_reg : POOL_CAP;
        no_page    = need_fresh && (fresh_reg >= limit);
        kp1        = need_fresh ? 10'd1 : ({1'b0, carve_reg[c_alloc]} + 10'd1);
        alloc_page = need_fresh ? fresh_reg[3:0] : class_page_reg[c_alloc];
        prod       = 21'(szc_pkg::CLASS_BYTES[c_alloc]) * 21'(kp1);
        alloc_addr = {alloc_page, prod[11:0]};
        free_owned = (q_item.addr != 16'd0)
                  && ((q_item.addr & szc_pkg::OFFSET_MASK) != 16'd0)
                  && (32'(free_page) < POOL_PAGES)
                  && ({1'b0, free_page} < fresh_reg)
                  && (32'(c_free) < szc_pkg::CLASS_COUNT);
        run        = (state_reg == szc_pkg::S_RUN) && q_valid;
        mem_we     = run && q_item.is_free && free_owned;
        mem_re     = run && !q_item.is_free && !q_item.oversize && stack_hit;
    end

    assign q_pop = run;

    // link memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[q_item.addr[15:3]] <= nonempty_reg[c_free] ? head_reg[c_free] : 16'd0;
        if (mem_re)
            link_rdata_reg <= link_mem[head_reg[c_alloc][15:3]];
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            link_cls_reg   <= c_alloc;
            link_entry_reg <= head_reg[c_alloc];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= szc_pkg::S_RUN;
            done_reg       <= 1'b0;
            addr_reg       <= 16'd0;
            status_reg     <= szc_pkg::ST_OK;
            fresh_reg      <= 5'(szc_pkg::CLASS_COUNT);
            page_limit_reg <= 5'd16;
            for (int i = 0; i < szc_pkg::CLASS_COUNT; i++)
            begin
                head_reg[i]       <= 16'd0;
                nonempty_reg[i]   <= 1'b0;
                carve_reg[i]      <= 9'd0;
                class_page_reg[i] <= 4'(i);
            end
            for (int p = 0; p < OWN_DEPTH; p++)
                owner_reg[p] <= (p < szc_pkg::CLASS_COUNT) ? 4'(p) : 4'd0;
        end
        else
        begin
            if (cfg_we)
                page_limit_reg <= cfg_wdata;
            done_reg <= 1'b0;
            unique case (state_reg)
                szc_pkg::S_RUN:
                begin
                    if (q_valid)
                    begin
                        addr_reg   <= 16'd0;
                        status_reg <= szc_pkg::ST_OK;
                        done_reg   <= 1'b1;
                        if (q_item.is_free)
                        begin
                            if (q_item.addr != 16'd0
                                && (q_item.addr & szc_pkg::OFFSET_MASK) == 16'd0)
                                status_reg <= szc_pkg::ST_ALIGNED;
                            else if (free_owned)
                            begin
                                head_reg[c_free]     <= q_item.addr;
                                nonempty_reg[c_free] <= 1'b1;
                            end
                        end
                        else if (q_item.oversize)
                            status_reg <= szc_pkg::ST_OVERSIZE;
                        else if (stack_hit)
                        begin
                            // result waits for the link word of the popped entry
                            done_reg  <= 1'b0;
                            state_reg <= szc_pkg::S_LINK;
                        end
                        else if (no_page)
                            status_reg <= szc_pkg::ST_NO_PAGE;
                        else
                        begin
                            addr_reg           <= alloc_addr;
                            carve_reg[c_alloc] <= 9'(kp1);
                            if (need_fresh)
                            begin
                                class_page_reg[c_alloc] <= fresh_reg[3:0];
                                if (32'(fresh_reg) < OWN_DEPTH)
                                    owner_reg[fresh_reg[3:0]] <= c_alloc;
                                fresh_reg <= fresh_reg + 5'd1;
                            end
                        end
                    end
                end
                szc_pkg::S_LINK:
                begin
                    head_reg[link_cls_reg]     <= link_rdata_reg;
                    nonempty_reg[link_cls_reg] <= (link_rdata_reg != 16'd0);
                    addr_reg                   <= link_entry_reg;
                    status_reg                 <= szc_pkg::ST_OK;
                    done_reg                   <= 1'b1;
                    state_reg                  <= szc_pkg::S_RUN;
                end
                default:
                    state_reg <= szc_pkg::S_RUN;
            endcase
        end
    end

    assign done          = done_reg;
    assign entry_address = addr_reg;
    assign status        = status_reg;

    a_link_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == szc_pkg::S_LINK |=> state_reg == szc_pkg::S_RUN && done_reg)
        else $error("link wait did not finish in one cycle");

    a_no_pop_in_link: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == szc_pkg::S_LINK |-> !q_pop)
        else $error("queue popped while waiting on link word");

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(q_pop) || $past(state_reg == szc_pkg::S_LINK))
        else $error("result with no request behind it");

    a_fresh_steps: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(fresh_reg) |-> fresh_reg == $past(fresh_reg) + 5'd1
                                && $past(fresh_reg) < $past(limit))
        else $error("fresh page counter moved wrongly");

    a_rw_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("link memory read and write in one cycle");

endmodule

// ===== sv/size_class_slab_allocator_top.sv =====
// A result strobes on done once the word has passed the queue and the back
// end; an allocate served from a freed-entry stack also waits in S_LINK for
// the registered link memory read. The back end takes one word per cycle
// except while it waits in S_LINK. busy is high while the queue is full.
// Reset (rst_n, async): all classes empty, pages 0..9 to classes 0..9,
// page_limit 16; link memory is not cleared and is undefined until written.
`timescale 1ns / 1ps

module size_class_slab_allocator_top #(
    parameter int POOL_PAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [15:0] request_size,
    input  logic [15:0] free_address,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    output logic        done,
    output logic [15:0] entry_address,
    output logic [1:0]  status
);

    logic          q_full;
    logic          push;
    logic          q_valid;
    logic          q_pop;
    szc_pkg::req_t front_item;
    szc_pkg::req_t head_item;

    szc_front u_front (
        .start        (start),
        .op           (op),
        .request_size (request_size),
        .free_address (free_address),
        .q_full       (q_full),
        .busy         (busy),
        .push         (push),
        .item         (front_item)
    );

    szc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (front_item),
        .pop     (q_pop),
        .full    (q_full),
        .valid   (q_valid),
        .rd_item (head_item)
    );

    szc_back #(
        .POOL_PAGES (POOL_PAGES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .done          (done),
        .entry_address (entry_address),
        .status        (status)
    );

endmodule
